// ===== rtl/core/cprp_pkg.sv =====
// Shared widths, codes and beat types of the ring pointer manager.
package cprp_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int LEN_W    = 25;
    localparam int SIZE_W   = 25;
    localparam int ADDR_W   = 32;
    localparam int PAD_W    = 26;
    localparam int OCC_W    = 24;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Build defaults
    localparam int DEF_MAX_BUFFER_BYTES = 16777216;
    localparam int SIZE_RESET           = 16777216;
    localparam int ADD_DIGIT            = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RESERVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADV_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ADV_READ  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERWRITE = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVERREAD  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] address;
    } req_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] end_address;
        logic [PAD_W-1:0]  padded_length;
        logic [OCC_W-1:0]  occupancy;
        logic [ADDR_W-1:0] write_address;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_item_t;

endpackage

// ===== rtl/core/cprp_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
interface cprp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/coded_picture_ring_pointer_manager.sv =====
// Top level: ring buffer pointer manager with serial remainder and address adders.
//
//   channel  dir   payload                               beat taken when
//   req      in    op, length, address                   req.valid & req.ready
//   rsp      out   status, start/end address, padded,    rsp.valid & rsp.ready
//                  occupancy, write_address
//   cfg      in    index, data                           cfg.valid & cfg.ready
//
// An item steps through the sequencer states from accept to result; a non-zero alignment adds
// a bit-serial remainder over the 25 length bits before placement.
// The three 32-bit address sums run 4 bits a cycle in parallel lanes.
// One item is in flight; req.ready rises again once its result sits in the output
// register, so the next item starts while that result waits on rsp.ready.
// Reset clears both offsets and loads the register defaults; cfg is always ready.
module coded_picture_ring_pointer_manager #(
    parameter int MAX_BUFFER_BYTES = cprp_pkg::DEF_MAX_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    cprp_chan_if.sink   req,
    cprp_chan_if.source rsp,
    cprp_chan_if.sink   cfg
);
    localparam int SW  = cprp_pkg::SIZE_W;
    localparam int LW  = cprp_pkg::LEN_W;
    localparam int PW  = cprp_pkg::PAD_W;
    localparam int AW  = cprp_pkg::ADDR_W;
    localparam int OCW = cprp_pkg::OCC_W;
    localparam int STW = cprp_pkg::STAT_W;
    localparam int XW  = SW + 1;
    localparam int EW  = SW + 2;
    localparam int OW  = ($clog2(MAX_BUFFER_BYTES) < SW) ? $clog2(MAX_BUFFER_BYTES) : SW;
    localparam int SIZE_ALL = (1 << SW) - 1;
    localparam int CAP_INT  = (MAX_BUFFER_BYTES > SIZE_ALL) ? SIZE_ALL : MAX_BUFFER_BYTES;
    localparam int RST_INT  = (cprp_pkg::SIZE_RESET > CAP_INT) ? CAP_INT
                                                               : cprp_pkg::SIZE_RESET;
    localparam logic [SW-1:0] SIZE_CAP = SW'(CAP_INT);
    localparam logic [SW-1:0] SIZE_RST = SW'(RST_INT);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_PLACE = 4'd3;
    localparam logic [3:0] S_SPAN  = 4'd4;
    localparam logic [3:0] S_ADV   = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_RUN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // Control and configuration registers
    logic [3:0]     state_reg, state_next;
    logic [OW-1:0]  wo_reg, wo_next;
    logic [OW-1:0]  ro_reg, ro_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [SW-1:0]  size_reg, size_next;
    logic           wrap_reg, wrap_next;
    logic [SW-1:0]  align_reg, align_next;
    logic           out_valid_reg, out_valid_next;

    // Item payload registers
    logic [cprp_pkg::OP_W-1:0] op_reg, op_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [AW-1:0]  off_reg, off_next;
    logic [STW-1:0] status_reg, status_next;
    logic [PW-1:0]  padded_reg, padded_next;
    logic [OW-1:0]  s_reg, s_next;
    logic [EW-1:0]  e_reg, e_next;
    logic           span_ok_reg, span_ok_next;
    cprp_pkg::rsp_item_t out_reg, out_next;

    // Datapath helpers
    logic          div_start, div_done;
    logic [LW-1:0] div_rem;
    logic          add_start;
    logic [2:0]    add_done;
    logic [AW-1:0] sum_start, sum_end, sum_wa;
    logic [EW-1:0] place_sum;
    logic [OW-1:0] adv_nxt;
    logic          adv_range;
    logic [XW-1:0] occ_full;
    logic          out_free;

    // True when pt lies in the circular half-open span (lo, hi]
    function automatic logic in_span(input logic [EW-1:0] lo_v,
                                     input logic [EW-1:0] hi_v,
                                     input logic [EW-1:0] pt_v);
        logic r;
        if (lo_v <= hi_v)
            r = (pt_v > lo_v) && (pt_v <= hi_v);
        else
            r = (pt_v > lo_v) || (pt_v <= hi_v);
        return r;
    endfunction

    // Clamp a written buffer size to 1 .. MAX_BUFFER_BYTES
    function automatic logic [SW-1:0] sat_size(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        if (v == '0)
            r = SW'(1);
        else if (v > SIZE_CAP)
            r = SIZE_CAP;
        else
            r = v;
        return r;
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign add_start = (state_reg == S_LOAD);
    assign div_start = (state_reg == S_PREP) && (op_reg == cprp_pkg::OP_RESERVE)
                       && (len_reg <= size_reg) && (align_reg != '0);

    // Placement sum, advance target and occupancy
    assign place_sum = EW'(wo_reg) + EW'(padded_reg);
    assign adv_range = off_reg > AW'(size_reg);
    assign adv_nxt   = (off_reg == AW'(size_reg)) ? '0 : off_reg[OW-1:0];
    assign occ_full  = (wo_reg >= ro_reg) ? XW'(wo_reg) - XW'(ro_reg)
                                          : XW'(wo_reg) + XW'(size_reg) - XW'(ro_reg);

    cprp_div #(
        .W (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (len_reg),
        .divisor  (align_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    cprp_sadd #(
        .W (AW),
        .D (cprp_pkg::ADD_DIGIT)
    ) u_add_start (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (base_reg),
        .b     (AW'(s_reg)),
        .done  (add_done[0]),
        .sum   (sum_start)
    );

    cprp_sadd #(
        .W (AW),
        .D (cprp_pkg::ADD_DIGIT)
    ) u_add_end (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (base_reg),
        .b     (AW'(e_reg)),
        .done  (add_done[1]),
        .sum   (sum_end)
    );

    cprp_sadd #(
        .W (AW),
        .D (cprp_pkg::ADD_DIGIT)
    ) u_add_wa (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (base_reg),
        .b     (AW'(wo_reg)),
        .done  (add_done[2]),
        .sum   (sum_wa)
    );

    // Sequence one item and take configuration beats
    always_comb
    begin
        state_next     = state_reg;
        wo_next        = wo_reg;
        ro_next        = ro_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        wrap_next      = wrap_reg;
        align_next     = align_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        addr_next      = addr_reg;
        off_next       = off_reg;
        status_next    = status_reg;
        padded_next    = padded_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        span_ok_next   = span_ok_reg;
        out_next       = out_reg;

        // Drop the result once taken
        if (rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.payload.op;
                    len_next     = req.payload.length;
                    addr_next    = req.payload.address;
                    status_next  = cprp_pkg::ST_OK;
                    padded_next  = '0;
                    span_ok_next = 1'b0;
                    state_next   = S_PREP;
                end
            end
            S_PREP:
            begin
                case (op_reg) inside
                    cprp_pkg::OP_RESERVE:
                    begin
                        if (len_reg > size_reg)
                        begin
                            status_next = cprp_pkg::ST_TOO_LARGE;
                            state_next  = S_LOAD;
                        end
                        else if (align_reg != '0)
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            padded_next = PW'(len_reg);
                            state_next  = S_PLACE;
                        end
                    end
                    cprp_pkg::OP_ADV_WRITE, cprp_pkg::OP_ADV_READ:
                    begin
                        off_next   = addr_reg - base_reg;
                        state_next = S_ADV;
                    end
                    default:
                    begin
                        state_next = S_LOAD;
                    end
                endcase
            end
            S_DIV:
            begin
                // Round up: add the distance to the next multiple
                if (div_done)
                begin
                    if (div_rem == '0)
                        padded_next = PW'(len_reg);
                    else
                        padded_next = PW'(len_reg) + PW'(align_reg) - PW'(div_rem);
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (place_sum >= EW'(size_reg))
                begin
                    if (wrap_reg)
                    begin
                        s_next = wo_reg;
                        e_next = place_sum - EW'(size_reg);
                    end
                    else
                    begin
                        s_next = '0;
                        e_next = EW'(padded_reg);
                    end
                end
                else
                begin
                    s_next = wo_reg;
                    e_next = place_sum;
                end
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                if (in_span(EW'(wo_reg), e_reg, EW'(ro_reg)))
                    status_next = cprp_pkg::ST_OVERFLOW;
                else
                    span_ok_next = 1'b1;
                state_next = S_LOAD;
            end
            S_ADV:
            begin
                if (adv_range)
                begin
                    status_next = cprp_pkg::ST_RANGE;
                end
                else if (op_reg == cprp_pkg::OP_ADV_WRITE)
                begin
                    if (in_span(EW'(wo_reg), EW'(adv_nxt), EW'(ro_reg)))
                        status_next = cprp_pkg::ST_OVERWRITE;
                    else
                        wo_next = adv_nxt;
                end
                else
                begin
                    if (in_span(EW'(ro_reg), EW'(adv_nxt), EW'(wo_reg))
                        && (adv_nxt != wo_reg))
                        status_next = cprp_pkg::ST_OVERREAD;
                    else
                        ro_next = adv_nxt;
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (add_done[0])
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result to the output register when it is free
                if (out_free)
                begin
                    out_next.status        = status_reg;
                    out_next.start_address = span_ok_reg ? sum_start : '0;
                    out_next.end_address   = span_ok_reg ? sum_end : '0;
                    out_next.padded_length = padded_reg;
                    out_next.occupancy     = occ_full[OCW-1:0];
                    out_next.write_address = sum_wa;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write a configuration register
        if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                cprp_pkg::REG_BASE:  base_next = cfg.payload.data;
                cprp_pkg::REG_SIZE:
                begin
                    size_next = sat_size(cfg.payload.data[SW-1:0]);
                    wo_next   = '0;
                    ro_next   = '0;
                end
                cprp_pkg::REG_WRAP:  wrap_next  = cfg.payload.data[0];
                cprp_pkg::REG_ALIGN: align_next = cfg.payload.data[SW-1:0];
                default:             base_next  = base_reg;
            endcase
        end
    end

    // Hold control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wo_reg        <= '0;
            ro_reg        <= '0;
            base_reg      <= '0;
            size_reg      <= SIZE_RST;
            wrap_reg      <= 1'b1;
            align_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wo_reg        <= wo_next;
            ro_reg        <= ro_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            wrap_reg      <= wrap_next;
            align_reg     <= align_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold item payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        len_reg     <= len_next;
        addr_reg    <= addr_next;
        off_reg     <= off_next;
        status_reg  <= status_next;
        padded_reg  <= padded_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        span_ok_reg <= span_ok_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_offsets_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(wo_reg) < size_reg) && (SW'(ro_reg) < size_reg))
        else $error("offset at or beyond buffer size");

    a_span_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.payload.status != cprp_pkg::ST_OK)
        |-> (rsp.payload.start_address == '0) && (rsp.payload.end_address == '0))
        else $error("span addresses on a failed item");

    a_no_pad_too_large: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.payload.status == cprp_pkg::ST_TOO_LARGE)
        |-> (rsp.payload.padded_length == '0))
        else $error("padded length on a too-large reserve");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder finished outside its wait state");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        add_done[0] |-> add_done[1] && add_done[2] && (state_reg == S_RUN))
        else $error("address lanes out of step");
`endif
endmodule

// ===== rtl/core/cprp_div.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module cprp_div #(
    parameter int W = cprp_pkg::LEN_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    shifted;
    logic [W+1:0]  trial;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = {1'b0, shifted} - {2'b00, dsr_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = trial[W+1] ? shifted[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule

// ===== rtl/core/cprp_sadd.sv =====
// Digit-serial adder, D bits a cycle from the least significant end.
module cprp_sadd #(
    parameter int W = cprp_pkg::ADDR_W,
    parameter int D = cprp_pkg::ADD_DIGIT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] sum
);
    localparam int NS = W / D;
    localparam int CW = $clog2(NS + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          carry_reg, carry_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  sum_reg, sum_next;
    logic [D:0]    dsum;

    // Add one digit and shift it in at the top of the sum
    always_comb
    begin
        dsum       = {1'b0, a_reg[D-1:0]} + {1'b0, b_reg[D-1:0]} + (D+1)'(carry_reg);
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        carry_next = carry_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sum_next   = sum_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            carry_next = 1'b0;
            a_next     = a;
            b_next     = b;
        end
        else if (run_reg)
        begin
            carry_next = dsum[D];
            sum_next   = {dsum[D-1:0], sum_reg[W-1:D]};
            a_next     = a_reg >> D;
            b_next     = b_reg >> D;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operand and sum shift registers
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        sum_reg   <= sum_next;
    end

    assign done = done_reg;
    assign sum  = sum_reg;
endmodule

// ===== bench/ring_pointer_checker.sv =====
// Watches the request, result and register channels, predicts each result and compares it.
`timescale 1ns / 1ps

module ring_pointer_checker #(
    parameter int MAX_BUFFER_BYTES = cprp_pkg::DEF_MAX_BUFFER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  cprp_pkg::req_item_t req_beat,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  cprp_pkg::rsp_item_t rsp_beat,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  cprp_pkg::cfg_item_t cfg_beat,
    output int                  errors,
    output int                  outstanding
);

    localparam int AW  = cprp_pkg::ADDR_W;
    localparam int SW  = cprp_pkg::SIZE_W;
    localparam int OCW = cprp_pkg::OCC_W;
    localparam int PW  = cprp_pkg::PAD_W;

    // Register copies and pointer state
    logic [AW-1:0]  base_reg;
    logic [SW-1:0]  size_reg;
    logic           wrap_reg;
    logic [SW-1:0]  align_reg;
    logic [OCW-1:0] wr_off;
    logic [OCW-1:0] rd_off;

    cprp_pkg::rsp_item_t due_results[$];
    cprp_pkg::rsp_item_t want;

    // True when probe lies in the circular span (start_off, end_off]
    function automatic logic span_holds(input logic [31:0] start_off, input logic [31:0] end_off,
                                        input logic [31:0] probe);
        if (start_off <= end_off)
        begin
            return probe > start_off && probe <= end_off;
        end
        return probe > start_off || probe <= end_off;
    endfunction

    // Apply one request beat to the pointer state and build its result
    function automatic cprp_pkg::rsp_item_t ring_response(input cprp_pkg::req_item_t beat);
        cprp_pkg::rsp_item_t r;
        logic [31:0] ring;
        logic [31:0] wo;
        logic [31:0] ro;
        logic [31:0] len;
        logic [31:0] align32;
        logic [31:0] pad;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] nxt;
        logic [31:0] occ;
        r = '0;
        r.status = cprp_pkg::ST_OK;
        ring = 32'(size_reg);
        if (ring < 32'd1)
        begin
            ring = 32'd1;
        end
        if (ring > MAX_BUFFER_BYTES)
        begin
            ring = 32'(MAX_BUFFER_BYTES);
        end
        wo = 32'(wr_off);
        ro = 32'(rd_off);
        len = 32'(beat.length);
        align32 = 32'(align_reg);
        case (beat.op) inside
            cprp_pkg::OP_RESERVE:
            begin
                if (len > ring)
                begin
                    r.status = cprp_pkg::ST_TOO_LARGE;
                end
                else
                begin
                    pad = len;
                    if (align32 != 32'd0 && (len % align32) != 32'd0)
                    begin
                        pad = (len / align32 + 32'd1) * align32;
                    end
                    // Wrap round the end, or restart at offset zero
                    if (wo + pad >= ring)
                    begin
                        lo = wrap_reg ? wo : 32'd0;
                        hi = wrap_reg ? wo + pad - ring : pad;
                    end
                    else
                    begin
                        lo = wo;
                        hi = wo + pad;
                    end
                    r.padded_length = pad[PW-1:0];
                    if (span_holds(wo, hi, ro))
                    begin
                        r.status = cprp_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        r.start_address = base_reg + lo;
                        r.end_address = base_reg + hi;
                    end
                end
            end
            cprp_pkg::OP_ADV_WRITE, cprp_pkg::OP_ADV_READ:
            begin
                nxt = beat.address - base_reg;
                if (nxt > ring)
                begin
                    r.status = cprp_pkg::ST_RANGE;
                end
                else
                begin
                    if (nxt == ring)
                    begin
                        nxt = 32'd0;
                    end
                    if (beat.op == cprp_pkg::OP_ADV_WRITE)
                    begin
                        if (span_holds(wo, nxt, ro))
                        begin
                            r.status = cprp_pkg::ST_OVERWRITE;
                        end
                        else
                        begin
                            wo = nxt;
                        end
                    end
                    else if (span_holds(ro, nxt, wo) && nxt != wo)
                    begin
                        r.status = cprp_pkg::ST_OVERREAD;
                    end
                    else
                    begin
                        ro = nxt;
                    end
                end
            end
            default:
            begin
            end
        endcase
        wr_off = wo[OCW-1:0];
        rd_off = ro[OCW-1:0];
        occ = (wo >= ro) ? wo - ro : wo + ring - ro;
        r.occupancy = occ[OCW-1:0];
        r.write_address = base_reg + wo;
        return r;
    endfunction

    // Track register writes, queue predictions, compare each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg = '0;
            size_reg = SW'(cprp_pkg::SIZE_RESET);
            wrap_reg = 1'b1;
            align_reg = '0;
            wr_off = '0;
            rd_off = '0;
            due_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_beat.index)
                    cprp_pkg::REG_BASE:
                    begin
                        base_reg = cfg_beat.data;
                    end
                    cprp_pkg::REG_SIZE:
                    begin
                        // Resizing clears both pointers
                        size_reg = cfg_beat.data[SW-1:0];
                        wr_off = '0;
                        rd_off = '0;
                    end
                    cprp_pkg::REG_WRAP:
                    begin
                        wrap_reg = cfg_beat.data[0];
                    end
                    default:
                    begin
                        align_reg = cfg_beat.data[SW-1:0];
                    end
                endcase
            end
            if (req_valid && req_ready)
            begin
                due_results.push_back(ring_response(req_beat));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR %0t: result beat with none pending, status %0d",
                                 $time, rsp_beat.status);
                    end
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp_beat.status !== want.status
                        || rsp_beat.start_address !== want.start_address
                        || rsp_beat.end_address !== want.end_address
                        || rsp_beat.padded_length !== want.padded_length
                        || rsp_beat.occupancy !== want.occupancy
                        || rsp_beat.write_address !== want.write_address)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("ERROR %0t: result mismatch (expected/actual)", $time);
                            $display("  status %0d/%0d start %h/%h end %h/%h",
                                     want.status, rsp_beat.status,
                                     want.start_address, rsp_beat.start_address,
                                     want.end_address, rsp_beat.end_address);
                            $display("  padded %h/%h occupancy %h/%h write_address %h/%h",
                                     want.padded_length, rsp_beat.padded_length,
                                     want.occupancy, rsp_beat.occupancy,
                                     want.write_address, rsp_beat.write_address);
                        end
                    end
                end
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the ring pointer manager bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int OPW = cprp_pkg::OP_W;
    localparam int LW  = cprp_pkg::LEN_W;
    localparam int SW  = cprp_pkg::SIZE_W;
    localparam int AW  = cprp_pkg::ADDR_W;
    localparam int CIW = cprp_pkg::CFG_IDX_W;
    localparam int CDW = cprp_pkg::CFG_DAT_W;

    localparam logic [OPW-1:0] OP_UNUSED   = 2'd3;
    localparam int unsigned    CYCLE_LIMIT = 500000;
    localparam int unsigned    STALL_HOLD  = 300;
    localparam int unsigned    TAIL_WAIT   = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int          fault_count;
    int          results_due;
    int unsigned cycle_count = 0;

    // Stimulus controls and the ring setting in use
    bit          req_gaps = 1'b1;
    bit          rsp_gaps = 1'b1;
    bit          hold_pending = 1'b0;
    logic [31:0] ring_base = '0;
    int unsigned ring_len = cprp_pkg::DEF_MAX_BUFFER_BYTES;

    cprp_chan_if #(.payload_t(cprp_pkg::req_item_t)) req_ch ();
    cprp_chan_if #(.payload_t(cprp_pkg::rsp_item_t)) rsp_ch ();
    cprp_chan_if #(.payload_t(cprp_pkg::cfg_item_t)) cfg_ch ();

    coded_picture_ring_pointer_manager uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ring_pointer_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_beat    (req_ch.payload),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_beat    (rsp_ch.payload),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_beat    (cfg_ch.payload),
        .errors      (fault_count),
        .outstanding (results_due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: ready bursts, random stalls, one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (STALL_HOLD) @(posedge clk);
            end
            else if (rsp_gaps && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one request beat and hold it until taken
    task automatic send_beat(input logic [OPW-1:0] op, input logic [LW-1:0] len,
                             input logic [AW-1:0] addr);
        cprp_pkg::req_item_t beat;
        beat.op = op;
        beat.length = len;
        beat.address = addr;
        if (req_gaps && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_ch.payload <= beat;
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
        cprp_pkg::cfg_item_t beat;
        beat.index = idx;
        beat.data = data;
        cfg_ch.payload <= beat;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Write all four registers; the block must be idle
    task automatic set_ring(input logic [31:0] base, input logic [SW-1:0] size,
                            input logic wrap, input logic [SW-1:0] align);
        put_reg(cprp_pkg::REG_BASE, base);
        put_reg(cprp_pkg::REG_SIZE, CDW'(size));
        put_reg(cprp_pkg::REG_WRAP, CDW'(wrap));
        put_reg(cprp_pkg::REG_ALIGN, CDW'(align));
        cfg_ch.valid <= 1'b0;
        ring_base = base;
        ring_len = 32'(size);
        if (ring_len < 1)
        begin
            ring_len = 1;
        end
        if (ring_len > cprp_pkg::DEF_MAX_BUFFER_BYTES)
        begin
            ring_len = cprp_pkg::DEF_MAX_BUFFER_BYTES;
        end
    endtask

    // Random beat aimed mostly at the current ring
    task automatic send_random();
        logic [OPW-1:0] op;
        logic [LW-1:0]  len;
        logic [AW-1:0]  addr;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        len = LW'($urandom());
        addr = $urandom();
        if (pick < 34)
        begin
            op = cprp_pkg::OP_RESERVE;
            case ($urandom_range(0, 9)) inside
                [0:3]:   len = LW'($urandom_range(0, ring_len / 8));
                [4:7]:   len = LW'($urandom_range(0, ring_len));
                8:       len = LW'(ring_len);
                default: len = LW'($urandom());
            endcase
        end
        else if (pick < 96)
        begin
            op = (pick < 65) ? cprp_pkg::OP_ADV_WRITE : cprp_pkg::OP_ADV_READ;
            case ($urandom_range(0, 19)) inside
                0:       addr = ring_base + ring_len;
                1:       addr = ring_base - $urandom_range(1, 64);
                [2:3]:   addr = $urandom();
                default: addr = ring_base + $urandom_range(0, ring_len);
            endcase
        end
        else
        begin
            op = OP_UNUSED;
        end
        send_beat(op, len, addr);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: empty spans, full-size spans, too large, pointer moves
        send_beat(cprp_pkg::OP_RESERVE, 25'd0, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd16777216, 32'hFFFF_FFFF);
        send_beat(cprp_pkg::OP_RESERVE, 25'd16777217, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'h1FF_FFFF, 32'd0);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'h0000_0100);
        send_beat(cprp_pkg::OP_ADV_READ, 25'h1FF_FFFF, 32'h0000_0080);
        send_beat(cprp_pkg::OP_ADV_READ, 25'd0, 32'h0000_0200);
        send_beat(cprp_pkg::OP_ADV_READ, 25'd0, 32'h0000_0100);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'd16777216);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'hFFFF_FFFF);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'd16777217);
        send_beat(OP_UNUSED, 25'h1FF_FFFF, 32'hFFFF_FFFF);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'h0000_0010);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'h0000_0200);
        send_beat(cprp_pkg::OP_RESERVE, 25'h100, 32'd0);
        drain();

        // Small ring near the top of the address space, restart mode, non-power-of-two alignment
        set_ring(32'hFFFF_FFF0, 25'd64, 1'b0, 25'd24);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'hFFFF_FFEF);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, 32'h0000_0018);
        send_beat(cprp_pkg::OP_RESERVE, 25'd20, 32'd0);
        send_beat(cprp_pkg::OP_ADV_READ, 25'd0, 32'h0000_000E);
        send_beat(cprp_pkg::OP_RESERVE, 25'd20, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd64, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd65, 32'd0);
        drain();

        // Size zero saturates to one byte
        set_ring($urandom(), 25'd0, 1'b1, 25'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd1, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd2, 32'd0);
        send_beat(cprp_pkg::OP_ADV_WRITE, 25'd0, ring_base + 1);
        drain();

        // Oversized register saturates to the maximum; alignment equal to the maximum buffer size
        set_ring($urandom(), 25'h1FF_FFFF, 1'b1, 25'd16777216);
        send_beat(cprp_pkg::OP_RESERVE, 25'd1, 32'd0);
        send_beat(cprp_pkg::OP_RESERVE, 25'd16777216, 32'd0);
        drain();

        // Random phases, each with its own ring setting
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_ring($urandom(), 25'd16, 1'b1, 25'd0);
                1: set_ring($urandom(), 25'd64, 1'b0, SW'($urandom_range(1, 12)));
                2: set_ring($urandom(), SW'($urandom_range(2, 256)), 1'b1,
                            SW'($urandom_range(0, 5)));
                3: set_ring(32'hFFFF_FF00 | $urandom_range(0, 255), 25'd16777216, 1'b1,
                            25'd4096);
                4: set_ring($urandom(), 25'd3, 1'b0, 25'd2);
                5: set_ring($urandom(), SW'($urandom_range(1, 4096)),
                            1'($urandom_range(0, 1)), SW'($urandom_range(0, 64)));
                6: set_ring($urandom(), 25'd1, 1'b1, 25'd16777216);
                default: set_ring($urandom(), 25'd100, 1'($urandom_range(0, 1)), 25'd7);
            endcase
            // No idling in the last part of the run
            req_gaps = (p < 6);
            rsp_gaps = (p < 6);
            for (int k = 0; k < 80; k++)
            begin
                if (p == 2 && k == 20)
                begin
                    hold_pending = 1'b1;
                end
                if (p == 4 && k == 40)
                begin
                    drain();
                end
                send_random();
            end
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
